[design/vmhq_pkg.sv]
// vmhq_pkg: shared constants for the vote map horizon query block.
// Field widths, register indexes and reset values, map size defaults.
// No dependencies.
`default_nettype none

package vmhq_pkg;

  // Default map geometry
  localparam int MAX_ROWS_DEF = 64;
  localparam int MAX_COLS_DEF = 64;

  // Field widths
  localparam int VOTE_W  = 24;  // unsigned Q16.8
  localparam int WGT_W   = 16;  // unsigned Q0.16
  localparam int STEP_W  = 8;
  localparam int CNT_W   = 7;   // rows_in_use / cols_in_use
  localparam int HOR_W   = 12;
  localparam int CELL_W  = 6;
  localparam int VX_W    = 14;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VOTE_STEP     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VOTE_WEIGHT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LINES_PRESENT = 3'd4;

  // Register reset values
  localparam logic [CNT_W-1:0]  ROWS_RST   = 7'd64;
  localparam logic [CNT_W-1:0]  COLS_RST   = 7'd64;
  localparam logic [STEP_W-1:0] STEP_RST   = 8'd15;
  localparam logic [WGT_W-1:0]  WEIGHT_RST = 16'd6554;

  // Item opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

endpackage

`default_nettype wire

[design/vote_map_horizon_query_top.sv]
// vote_map_horizon_query_top: vote map store with horizon confidence query.
// Holds the map in one synchronous RAM; row scans, two multiplies and a shared
// radix-2 divider. Depends on vmhq_pkg.
//
//  channel   direction  handshake            payload
//  in_       input      in_valid/in_ready    op, cell_row, cell_col, cell_vote, horizon_row
//  out_      output     out_valid/out_ready  confidence, vanish_x
//  cfg_      input      cfg_we               cfg_index, cfg_wdata
//
// A write item is written to the map RAM on its transfer and gives no result.
// A query runs from its transfer to its result through 12 divider steps for bin/offset,
// one RAM read per cell over the single read port for the effective column count of each
// scanned row (no reads for a row out of range), the multiplies and 32 divider steps for
// the final scaling.
// One item in flight at a time; a finished result waits in the output register while
// the next item is taken, and a later result holds until that register is free.
// rst_n is synchronous; the map RAM is not cleared.
`default_nettype none

module vote_map_horizon_query_top
  import vmhq_pkg::*;
#(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int MAX_COLS = MAX_COLS_DEF
) (
  input  wire                    clk,
  input  wire                    rst_n,
  // input items
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire                    in_op,
  input  wire [CELL_W-1:0]       in_cell_row,
  input  wire [CELL_W-1:0]       in_cell_col,
  input  wire [VOTE_W-1:0]       in_cell_vote,
  input  wire [HOR_W-1:0]        in_horizon_row,
  // results
  output logic                   out_valid,
  input  wire                    out_ready,
  output logic [VOTE_W-1:0]      out_confidence,
  output logic [VX_W-1:0]        out_vanish_x,
  // configuration
  input  wire                    cfg_we,
  input  wire [CFG_IDX_W-1:0]    cfg_index,
  input  wire [CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int DW    = 32;                 // divider dividend width
  localparam int PW    = VOTE_W + WGT_W;     // vote * weight
  localparam int ACW   = PW + STEP_W;        // accumulated numerator

  // State codes
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIV1  = 4'd1;
  localparam logic [3:0] S_SET0  = 4'd2;
  localparam logic [3:0] S_SCAN0 = 4'd3;
  localparam logic [3:0] S_SET1  = 4'd4;
  localparam logic [3:0] S_SCAN1 = 4'd5;
  localparam logic [3:0] S_MUL0A = 4'd6;
  localparam logic [3:0] S_MUL0B = 4'd7;
  localparam logic [3:0] S_MUL1A = 4'd8;
  localparam logic [3:0] S_MUL1B = 4'd9;
  localparam logic [3:0] S_LD2   = 4'd10;
  localparam logic [3:0] S_DIV2  = 4'd11;
  localparam logic [3:0] S_DONE  = 4'd12;

  // Configuration registers
  logic [CNT_W-1:0]  cfg_rows_r, cfg_cols_r;
  logic [STEP_W-1:0] cfg_step_r;
  logic [WGT_W-1:0]  cfg_weight_r;
  logic              cfg_lines_r;

  // Control and datapath registers
  logic [3:0]        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [HOR_W-1:0]  bin_r, bin_nxt;
  logic [STEP_W-1:0] off_r, off_nxt;
  logic [DW-1:0]     dvd_r, dvd_nxt;
  logic [STEP_W-1:0] rem_r, rem_nxt;
  logic [5:0]        cnt_r, cnt_nxt;
  logic [AW-1:0]     base_r, base_nxt;
  logic [CNT_W-1:0]  iss_r, iss_nxt;
  logic [CNT_W-1:0]  lim_r, lim_nxt;
  logic              rd_vld_r;
  logic [CNT_W-1:0]  rd_col_r;
  logic [VOTE_W-1:0] best_r, best_nxt;
  logic [CNT_W-1:0]  bcol_r, bcol_nxt;
  logic [VOTE_W-1:0] m0_r, m0_nxt, m1_r, m1_nxt;
  logic [CNT_W-1:0]  col_r, col_nxt;
  logic [PW-1:0]     p_r, p_nxt;
  logic [ACW-1:0]    acc_r, acc_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [VOTE_W-1:0] out_conf_r, out_conf_nxt;
  logic [VX_W-1:0]   out_vx_r, out_vx_nxt;

  // Map RAM
  logic [VOTE_W-1:0] mem [DEPTH];
  logic [VOTE_W-1:0] mem_q;
  logic              rd_en, wr_en;
  logic [AW-1:0]     rd_addr, wr_addr;

  // Effective counts and helpers
  logic [CNT_W-1:0]  rows_eff, cols_eff;
  logic [20:0]       wr_full;
  logic [8:0]        rem_sh, rem_sub;
  logic              ge;
  logic [STEP_W-1:0] rem_step;
  logic [DW-1:0]     dvd_step;
  logic [CNT_W-1:0]  row0_idx, row1_idx;
  logic              row0_ok, row1_ok;
  logic [20:0]       base0_full, base1_full;
  logic [14:0]       vx_full;
  logic              scanning;

  assign rows_eff = (11'(cfg_rows_r) > 11'(MAX_ROWS)) ? CNT_W'(MAX_ROWS) : cfg_rows_r;
  assign cols_eff = (11'(cfg_cols_r) > 11'(MAX_COLS)) ? CNT_W'(MAX_COLS) : cfg_cols_r;

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_confidence = out_conf_r;
  assign out_vanish_x   = out_vx_r;

  // Configuration writes; indexes outside the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_rows_r   <= ROWS_RST;
      cfg_cols_r   <= COLS_RST;
      cfg_step_r   <= STEP_RST;
      cfg_weight_r <= WEIGHT_RST;
      cfg_lines_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROWS_IN_USE:   cfg_rows_r   <= cfg_wdata[CNT_W-1:0];
        REG_COLS_IN_USE:   cfg_cols_r   <= cfg_wdata[CNT_W-1:0];
        REG_VOTE_STEP:     cfg_step_r   <= cfg_wdata[STEP_W-1:0];
        REG_VOTE_WEIGHT:   cfg_weight_r <= cfg_wdata[WGT_W-1:0];
        REG_LINES_PRESENT: cfg_lines_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Cell write address; cells outside the map are ignored
  assign wr_full = 21'(in_cell_row) * 21'(MAX_COLS) + 21'(in_cell_col);
  assign wr_addr = wr_full[AW-1:0];
  assign wr_en   = in_valid && in_ready && (in_op == OP_WRITE) &&
                   (11'(in_cell_row) < 11'(MAX_ROWS)) && (11'(in_cell_col) < 11'(MAX_COLS));

  // Row scan read port
  assign scanning = (state_r == S_SCAN0) || (state_r == S_SCAN1);
  assign rd_en    = scanning && (iss_r < lim_r);
  assign rd_addr  = base_r + AW'(iss_r);

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= in_cell_vote;
    if (rd_en) mem_q <= mem[rd_addr];
  end

  // One restoring divider step, shared by both divisions
  assign rem_sh   = {rem_r, dvd_r[DW-1]};
  assign ge       = rem_sh >= {1'b0, step_r};
  assign rem_sub  = rem_sh - {1'b0, step_r};
  assign rem_step = ge ? rem_sub[STEP_W-1:0] : rem_sh[STEP_W-1:0];
  assign dvd_step = {dvd_r[DW-2:0], ge};

  // Row range checks and row base addresses
  assign row0_idx   = dvd_r[CNT_W-1:0];
  assign row1_idx   = bin_r[CNT_W-1:0] + 7'd1;
  assign row0_ok    = dvd_r[HOR_W-1:0] < HOR_W'(rows_eff);
  assign row1_ok    = (13'(bin_r) + 13'd1) < 13'(rows_eff);
  assign base0_full = 21'(row0_idx) * 21'(MAX_COLS);
  assign base1_full = 21'(row1_idx) * 21'(MAX_COLS);
  assign vx_full    = 15'(step_r) * 15'(col_r);

  // Sequencer and datapath next state
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    bin_nxt       = bin_r;
    off_nxt       = off_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    base_nxt      = base_r;
    iss_nxt       = iss_r;
    lim_nxt       = lim_r;
    best_nxt      = best_r;
    bcol_nxt      = bcol_r;
    m0_nxt        = m0_r;
    m1_nxt        = m1_r;
    col_nxt       = col_r;
    p_nxt         = p_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r;
    out_conf_nxt  = out_conf_r;
    out_vx_nxt    = out_vx_r;

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    // running maximum, first maximum kept on ties
    if (rd_vld_r && (mem_q > best_r)) begin
      best_nxt = mem_q;
      bcol_nxt = rd_col_r;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid && (in_op == OP_QUERY)) begin
          step_nxt  = (cfg_step_r == '0) ? STEP_W'(1) : cfg_step_r;
          dvd_nxt   = {in_horizon_row, (DW-HOR_W)'(0)};
          rem_nxt   = '0;
          cnt_nxt   = 6'(HOR_W);
          state_nxt = S_DIV1;
        end
      end
      S_DIV1: begin
        dvd_nxt = dvd_step;
        rem_nxt = rem_step;
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == 6'd1) state_nxt = S_SET0;
      end
      S_SET0: begin
        bin_nxt   = dvd_r[HOR_W-1:0];
        off_nxt   = rem_r;
        base_nxt  = base0_full[AW-1:0];
        lim_nxt   = row0_ok ? cols_eff : '0;
        iss_nxt   = '0;
        best_nxt  = '0;
        bcol_nxt  = '0;
        state_nxt = S_SCAN0;
      end
      S_SCAN0: begin
        if (rd_en) begin
          iss_nxt = iss_r + 7'd1;
        end else if (!rd_vld_r) begin
          m0_nxt    = best_r;
          col_nxt   = bcol_r;
          state_nxt = S_SET1;
        end
      end
      S_SET1: begin
        base_nxt  = base1_full[AW-1:0];
        lim_nxt   = row1_ok ? cols_eff : '0;
        iss_nxt   = '0;
        best_nxt  = '0;
        bcol_nxt  = '0;
        state_nxt = S_SCAN1;
      end
      S_SCAN1: begin
        if (rd_en) begin
          iss_nxt = iss_r + 7'd1;
        end else if (!rd_vld_r) begin
          m1_nxt    = best_r;
          state_nxt = S_MUL0A;
        end
      end
      S_MUL0A: begin
        p_nxt     = PW'(m0_r) * PW'(cfg_weight_r);
        state_nxt = S_MUL0B;
      end
      S_MUL0B: begin
        acc_nxt   = ACW'(p_r) * ACW'(step_r - off_r);
        state_nxt = S_MUL1A;
      end
      S_MUL1A: begin
        p_nxt     = PW'(m1_r) * PW'(cfg_weight_r);
        state_nxt = S_MUL1B;
      end
      S_MUL1B: begin
        acc_nxt   = acc_r + ACW'(p_r) * ACW'(off_r);
        state_nxt = S_LD2;
      end
      S_LD2: begin
        // dividing by 2^16 first, then by step, gives the same floor
        dvd_nxt   = acc_r[ACW-1:16];
        rem_nxt   = '0;
        cnt_nxt   = 6'(DW);
        state_nxt = S_DIV2;
      end
      S_DIV2: begin
        dvd_nxt = dvd_step;
        rem_nxt = rem_step;
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == 6'd1) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_conf_nxt  = cfg_lines_r ? dvd_r[VOTE_W-1:0] : '0;
          out_vx_nxt    = vx_full[VX_W-1:0];
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_vld_r    <= rd_en;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    step_r     <= step_nxt;
    bin_r      <= bin_nxt;
    off_r      <= off_nxt;
    dvd_r      <= dvd_nxt;
    rem_r      <= rem_nxt;
    cnt_r      <= cnt_nxt;
    base_r     <= base_nxt;
    iss_r      <= iss_nxt;
    lim_r      <= lim_nxt;
    best_r     <= best_nxt;
    bcol_r     <= bcol_nxt;
    m0_r       <= m0_nxt;
    m1_r       <= m1_nxt;
    col_r      <= col_nxt;
    p_r        <= p_nxt;
    acc_r      <= acc_nxt;
    out_conf_r <= out_conf_nxt;
    out_vx_r   <= out_vx_nxt;
    if (rd_en) rd_col_r <= iss_r;
  end

  // Divider remainder stays below the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV1 || state_r == S_DIV2) |-> (rem_r < step_r))
    else $error("divider remainder not below step");

  // Scan never issues past its limit
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    scanning |-> (iss_r <= lim_r))
    else $error("scan counter past limit");

  // Read data only returns while a row scan is running
  a_rd_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> scanning)
    else $error("read data outside row scan");

  // Final quotient fits the confidence field
  a_conf_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |-> (dvd_r[DW-1:VOTE_W] == '0))
    else $error("confidence quotient overflow");

  // A write transfer never produces a result
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_op == OP_WRITE) && !out_valid_r) |=> !out_valid_r)
    else $error("result after write item");

endmodule

`default_nettype wire

[bench/tb_top.sv]
`timescale 1ns / 1ps
// tb_top: self-checking bench for vote_map_horizon_query_top.
// Keeps its own copy of the vote map and registers to predict every horizon query.
// Depends on vmhq_pkg and the design top.

module tb_top
  import vmhq_pkg::*;
();

  localparam int MAP_ROWS    = MAX_ROWS_DEF;
  localparam int MAP_COLS    = MAX_COLS_DEF;
  localparam int ITEM_TARGET = 1550;
  localparam int PHASE_ITEMS = 120;
  localparam int HOLD_OFF    = 2 * MAP_COLS + 80;  // longest query plus margin
  localparam int STALL_LIMIT = 4000;               // cycles without any transfer

  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef longint unsigned wide_t;

  typedef struct packed {
    logic [VOTE_W-1:0] confidence;
    logic [VX_W-1:0]   vanish_x;
  } horizon_res_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_op;
  logic [CELL_W-1:0]     in_cell_row;
  logic [CELL_W-1:0]     in_cell_col;
  logic [VOTE_W-1:0]     in_cell_vote;
  logic [HOR_W-1:0]      in_horizon_row;
  logic                  out_valid;
  logic                  out_ready;
  logic [VOTE_W-1:0]     out_confidence;
  logic [VX_W-1:0]       out_vanish_x;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  vote_map_horizon_query_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_cell_row    (in_cell_row),
    .in_cell_col    (in_cell_col),
    .in_cell_vote   (in_cell_vote),
    .in_horizon_row (in_horizon_row),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_confidence (out_confidence),
    .out_vanish_x   (out_vanish_x),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // local copy of the map and registers
  logic [VOTE_W-1:0] map_copy [MAP_ROWS*MAP_COLS];
  bit                cell_written [MAP_ROWS*MAP_COLS];
  logic [CNT_W-1:0]  rows_cfg;
  logic [CNT_W-1:0]  cols_cfg;
  logic [STEP_W-1:0] step_cfg;
  logic [WGT_W-1:0]  weight_cfg;
  logic              lines_cfg;

  horizon_res_t pending_results [$];
  int error_count     = 0;
  int writes_sent     = 0;
  int queries_sent    = 0;
  int results_checked = 0;
  int settings_done   = 0;
  int items_sent      = 0;
  int quiet_cycles    = 0;
  bit sender_steady   = 1'b0;

  function automatic int eff_rows();
    return (rows_cfg > MAP_ROWS) ? MAP_ROWS : int'(rows_cfg);
  endfunction

  function automatic int eff_cols();
    return (cols_cfg > MAP_COLS) ? MAP_COLS : int'(cols_cfg);
  endfunction

  function automatic int eff_step();
    return (step_cfg == 0) ? 1 : int'(step_cfg);
  endfunction

  // largest cell of a row, first occurrence wins; zero for a row not in use
  function automatic logic [VOTE_W-1:0] row_peak(input int row, output int peak_col);
    int c;
    logic [VOTE_W-1:0] best;
    best = '0;
    peak_col = 0;
    if (row >= eff_rows()) return '0;
    for (c = 0; c < eff_cols(); c++) begin
      if (map_copy[row*MAP_COLS+c] > best) begin
        best = map_copy[row*MAP_COLS+c];
        peak_col = c;
      end
    end
    return best;
  endfunction

  // blend of the two row peaks and column of the bin row peak
  function automatic horizon_res_t predict_horizon(input logic [HOR_W-1:0] horizon);
    int s, bin, off, col, unused_col;
    longint unsigned m0, m1, num;
    horizon_res_t res;
    s   = eff_step();
    bin = int'(horizon) / s;
    off = int'(horizon) % s;
    m0  = row_peak(bin, col);
    m1  = row_peak(bin + 1, unused_col);
    res.confidence = '0;
    if (lines_cfg) begin
      num = m0 * weight_cfg * wide_t'(s - off)
          + m1 * weight_cfg * wide_t'(off);
      res.confidence = VOTE_W'(num / (wide_t'(s) << 16));
    end
    res.vanish_x = VX_W'(s * col);
    return res;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int idle_len();
    int pick;
    pick = $urandom_range(99, 0);
    if (pick < 80) return $urandom_range(3, 1);
    if (pick < 96) return $urandom_range(15, 4);
    return $urandom_range(80, 30);
  endfunction

  function automatic logic [VOTE_W-1:0] pick_vote();
    int pick;
    pick = $urandom_range(99, 0);
    if (pick < 25) return '1;
    if (pick < 40) return '0;
    if (pick < 60) return VOTE_W'($urandom_range(3, 0));
    return VOTE_W'($urandom);
  endfunction

  // bins near the rows in use, with the edges and the odd full-range horizon
  function automatic logic [HOR_W-1:0] pick_horizon();
    int s, bin, top, pick, h;
    s    = eff_step();
    pick = $urandom_range(99, 0);
    if (pick < 10 && eff_cols() <= 16) return HOR_W'($urandom);
    top = (eff_cols() > 16) ? 4 : eff_rows() + 1;
    if (pick < 25 && eff_rows() > 0)
      bin = eff_rows() - int'($urandom_range(1, 0));
    else
      bin = $urandom_range(top, 0);
    h = bin * s + int'($urandom_range(s - 1, 0));
    return (h > 4095) ? HOR_W'(4095) : HOR_W'(h);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] with_junk(input logic [CFG_DATA_W-1:0] value,
                                                      input int width);
    logic [CFG_DATA_W-1:0] junk;
    junk = ($urandom_range(3, 0) == 0) ? CFG_DATA_W'($urandom) : '0;
    return (junk << width) | value;
  endfunction

  // one input transfer; the predictor follows at the accepting edge
  task automatic send_item(input logic op, input logic [CELL_W-1:0] row,
                           input logic [CELL_W-1:0] col, input logic [VOTE_W-1:0] vote,
                           input logic [HOR_W-1:0] horizon);
    int gap;
    @(negedge clk);
    in_valid       = 1'b1;
    in_op          = op;
    in_cell_row    = row;
    in_cell_col    = col;
    in_cell_vote   = vote;
    in_horizon_row = horizon;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (op == OP_WRITE) begin
      map_copy[int'(row)*MAP_COLS+int'(col)]     = vote;
      cell_written[int'(row)*MAP_COLS+int'(col)] = 1'b1;
      writes_sent++;
    end else begin
      pending_results = {pending_results, predict_horizon(horizon)};
      queries_sent++;
    end
    gap = (!sender_steady && $urandom_range(1, 0) == 1) ? idle_len() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic write_cell(input int row, input int col, input logic [VOTE_W-1:0] vote);
    send_item(OP_WRITE, CELL_W'(row), CELL_W'(col), vote, HOR_W'($urandom));
  endtask

  // a query may only touch cells already written, so fill any gaps first
  task automatic query_horizon(input logic [HOR_W-1:0] horizon);
    int bin, r, c;
    bin = int'(horizon) / eff_step();
    for (r = bin; r <= bin + 1; r++) begin
      if (r < eff_rows()) begin
        for (c = 0; c < eff_cols(); c++)
          if (!cell_written[r*MAP_COLS+c]) write_cell(r, c, pick_vote());
      end
    end
    send_item(OP_QUERY, CELL_W'($urandom), CELL_W'($urandom), VOTE_W'($urandom), horizon);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (HOLD_OFF) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_ROWS_IN_USE:   rows_cfg   = data[CNT_W-1:0];
      REG_COLS_IN_USE:   cols_cfg   = data[CNT_W-1:0];
      REG_VOTE_STEP:     step_cfg   = data[STEP_W-1:0];
      REG_VOTE_WEIGHT:   weight_cfg = data[WGT_W-1:0];
      REG_LINES_PRESENT: lines_cfg  = data[0];
      default: ;
    endcase
  endtask

  // all five registers, only once the block has gone quiet
  task automatic apply_setting(input int rows, input int cols, input int step,
                               input int weight, input int lines);
    wait_drained();
    cfg_write(REG_ROWS_IN_USE, with_junk(CFG_DATA_W'(rows), CNT_W));
    cfg_write(REG_COLS_IN_USE, with_junk(CFG_DATA_W'(cols), CNT_W));
    cfg_write(REG_VOTE_STEP, with_junk(CFG_DATA_W'(step), STEP_W));
    cfg_write(REG_VOTE_WEIGHT, CFG_DATA_W'(weight));
    cfg_write(REG_LINES_PRESENT, with_junk(CFG_DATA_W'(lines), 1));
    settings_done++;
  endtask

  task automatic random_setting();
    int rows, cols, step, weight, pick;
    pick = $urandom_range(9, 0);
    rows = (pick == 0) ? 0 : (pick == 1) ? 64 : (pick == 2) ? $urandom_range(127, 65)
         : $urandom_range(64, 1);
    pick = $urandom_range(9, 0);
    cols = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(127, 64) : $urandom_range(12, 1);
    pick = $urandom_range(9, 0);
    step = (pick == 0) ? 0 : (pick == 1) ? 1 : (pick == 2) ? 255 : $urandom_range(255, 1);
    pick = $urandom_range(9, 0);
    weight = (pick == 0) ? 0 : (pick == 1) ? 65535 : $urandom_range(65535, 0);
    apply_setting(rows, cols, step, weight, ($urandom_range(4, 0) != 0) ? 1 : 0);
  endtask

  // register values straight out of reset: bins beyond the map, no lines
  task automatic test_reset_values();
    query_horizon(HOR_W'(4095));
    query_horizon(HOR_W'(960));
  endtask

  // small hand-built map: ties, an all-zero row, peak in the last column
  task automatic test_known_map();
    int r, c;
    logic [VOTE_W-1:0] seed_votes [16] = '{
      24'd5, 24'hFFFFFF, 24'd7, 24'hFFFFFF,
      24'd0, 24'd0, 24'd0, 24'd0,
      24'd3, 24'd3, 24'd3, 24'd3,
      24'd0, 24'd0, 24'd0, 24'd1};
    apply_setting(4, 4, 15, 65535, 1);
    cfg_write(REG_SPARE_LO, CFG_DATA_W'($urandom));
    cfg_write(REG_SPARE_HI, CFG_DATA_W'($urandom));
    for (r = 0; r < 4; r++)
      for (c = 0; c < 4; c++) write_cell(r, c, seed_votes[r*4+c]);
    query_horizon(HOR_W'(0));
    query_horizon(HOR_W'(14));
    query_horizon(HOR_W'(22));
    query_horizon(HOR_W'(50));
    query_horizon(HOR_W'(60));
    query_horizon(HOR_W'(4095));
  endtask

  // zero step, widest step, zero weight, no lines, empty and saturated counts
  task automatic test_edge_settings();
    apply_setting(4, 4, 0, 40000, 1);
    query_horizon(HOR_W'(3));
    query_horizon(HOR_W'(2));
    query_horizon(HOR_W'(4095));
    apply_setting(4, 4, 255, 65535, 1);
    query_horizon(HOR_W'(254));
    query_horizon(HOR_W'(4095));
    apply_setting(4, 4, 15, 0, 1);
    query_horizon(HOR_W'(7));
    apply_setting(4, 4, 15, 65535, 0);
    query_horizon(HOR_W'(20));
    apply_setting(0, 4, 15, 65535, 1);
    query_horizon(HOR_W'(0));
    apply_setting(4, 0, 15, 65535, 1);
    query_horizon(HOR_W'(14));
    apply_setting(127, 4, 15, 65535, 1);
    query_horizon(HOR_W'(60));
    query_horizon(HOR_W'(950));
  endtask

  // phases of mixed writes and queries, each under a fresh register setting
  task automatic test_random_traffic();
    int phase, n, row, col;
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      case (phase)
        0:       apply_setting(1, 1, 1, 0, 1);
        1:       apply_setting(64, 64, 255, 65535, 1);
        2:       apply_setting(127, 127, 0, 65535, 1);
        default: random_setting();
      endcase
      sender_steady = ($urandom_range(4, 0) == 0);
      for (n = 0; n < PHASE_ITEMS && items_sent < ITEM_TARGET; n++) begin
        if ($urandom_range(99, 0) < 40) begin
          row = ($urandom_range(9, 0) < 7 && eff_rows() > 0) ?
                $urandom_range(eff_rows() - 1, 0) : $urandom_range(MAP_ROWS - 1, 0);
          col = ($urandom_range(9, 0) < 7 && eff_cols() > 0) ?
                $urandom_range(eff_cols() - 1, 0) : $urandom_range(MAP_COLS - 1, 0);
          write_cell(row, col, pick_vote());
        end else begin
          query_horizon(pick_horizon());
        end
      end
      phase++;
    end
    sender_steady = 1'b0;
  endtask

  // result side: ready held high or low for random runs
  initial begin
    int run;
    bit level;
    out_ready = 1'b0;
    run   = 0;
    level = 1'b0;
    forever begin
      @(negedge clk);
      if (run == 0) begin
        level = !level;
        if (level)
          run = ($urandom_range(9, 0) == 0) ? $urandom_range(300, 60) : $urandom_range(30, 1);
        else
          run = idle_len();
      end
      out_ready = level;
      run--;
    end
  end

  // compare every result transfer with the oldest prediction
  always @(posedge clk) begin
    horizon_res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected: confidence %0h vanish_x %0d",
                 $time, out_confidence, out_vanish_x);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (out_confidence !== want.confidence) begin
          $display("%0t: confidence mismatch: expected %0h, actual %0h",
                   $time, want.confidence, out_confidence);
          error_count++;
        end
        if (out_vanish_x !== want.vanish_x) begin
          $display("%0t: vanish_x mismatch: expected %0d, actual %0d",
                   $time, want.vanish_x, out_vanish_x);
          error_count++;
        end
      end
    end
  end

  // watchdog on cycles with no transfer on any port
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: watchdog: no transfer for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, pending_results.size());
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    in_valid       = 1'b0;
    in_op          = OP_WRITE;
    in_cell_row    = '0;
    in_cell_col    = '0;
    in_cell_vote   = '0;
    in_horizon_row = '0;
    cfg_we         = 1'b0;
    cfg_index      = REG_ROWS_IN_USE;
    cfg_wdata      = '0;
    rst_n          = 1'b0;
    rows_cfg       = ROWS_RST;
    cols_cfg       = COLS_RST;
    step_cfg       = STEP_RST;
    weight_cfg     = WEIGHT_RST;
    lines_cfg      = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_values();
    test_known_map();
    test_edge_settings();
    test_random_traffic();
    wait_drained();

    $display("summary: %0d cell writes and %0d horizon queries, %0d results compared",
             writes_sent, queries_sent, results_checked);
    $display("summary: %0d register settings applied, %0d mismatches",
             settings_done, error_count);
    if (error_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

[files.f]
design/vmhq_pkg.sv
design/vote_map_horizon_query_top.sv
bench/tb_top.sv
